@@ hdl/assert_macros.svh @@
// assertion helpers used by rectangle_collide_split
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent implies consequent sequence, same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed");

`endif

@@ hdl/rcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants of the rectangle collision splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

   localparam int unsigned COORD_BITS_DEF = 13;

   typedef enum logic [2:0] {
      V_NONE        = 3'd0,
      V_RES_COVERED = 3'd1,
      V_NEW_COVERED = 3'd2,
      V_RES_TRIMMED = 3'd3,
      V_NEW_BROKEN  = 3'd4,
      V_MERGED      = 3'd5
   } verdict_type;

endpackage

`default_nettype wire

@@ hdl/rcs_classify.sv @@
// ----------------------------------------------------------------------------
// rcs_classify
// Combinational classification of one resident/new rectangle pair and
// computation of up to two result rectangles.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_classify #(
   parameter int unsigned COORD_BITS = rcs_pkg::COORD_BITS_DEF
) (
   input  logic [COORD_BITS-1:0]   res_x,
   input  logic [COORD_BITS-1:0]   res_y,
   input  logic [COORD_BITS-1:0]   res_w,
   input  logic [COORD_BITS-1:0]   res_h,
   input  logic [COORD_BITS-1:0]   new_x,
   input  logic [COORD_BITS-1:0]   new_y,
   input  logic [COORD_BITS-1:0]   new_w,
   input  logic [COORD_BITS-1:0]   new_h,
   output rcs_pkg::verdict_type    verdict,
   output logic [1:0]              piece_count,
   output logic [COORD_BITS:0]     first_x,
   output logic [COORD_BITS:0]     first_y,
   output logic [COORD_BITS+1:0]   first_w,
   output logic [COORD_BITS+1:0]   first_h,
   output logic [COORD_BITS:0]     second_x,
   output logic [COORD_BITS:0]     second_y,
   output logic [COORD_BITS+1:0]   second_w,
   output logic [COORD_BITS+1:0]   second_h
);
   import rcs_pkg::*;

   localparam int unsigned P = COORD_BITS + 1;
   localparam int unsigned S = COORD_BITS + 2;

   // edges, exact in P bits
   logic [P-1:0] ra, rb, rt, rd, na, nb, nt, nd;
   // same values widened for size arithmetic (mod 2^S)
   logic [S-1:0] ras, rbs, rts, rds, nas, nbs, nts, nds;
   logic [S-1:0] rws, rhs, nws, nhs;
   logic [3:0]   e1, e2;
   logic [2:0]   t1, t2;
   logic         cov_res, cov_new, apart, both2;
   logic         same_w, same_h;

   function automatic logic encl(input logic [P-1:0] px, input logic [P-1:0] py,
                                 input logic [P-1:0] lx, input logic [P-1:0] hx,
                                 input logic [P-1:0] ly, input logic [P-1:0] hy);
      return (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
   endfunction

   assign ra = {1'b0, res_x};
   assign rb = {1'b0, res_x} + {1'b0, res_w};
   assign rt = {1'b0, res_y};
   assign rd = {1'b0, res_y} + {1'b0, res_h};
   assign na = {1'b0, new_x};
   assign nb = {1'b0, new_x} + {1'b0, new_w};
   assign nt = {1'b0, new_y};
   assign nd = {1'b0, new_y} + {1'b0, new_h};

   assign ras = {1'b0, ra};
   assign rbs = {1'b0, rb};
   assign rts = {1'b0, rt};
   assign rds = {1'b0, rd};
   assign nas = {1'b0, na};
   assign nbs = {1'b0, nb};
   assign nts = {1'b0, nt};
   assign nds = {1'b0, nd};
   assign rws = {2'b00, res_w};
   assign rhs = {2'b00, res_h};
   assign nws = {2'b00, new_w};
   assign nhs = {2'b00, new_h};

   assign cov_res = (ra >= na) && (rb <= nb) && (rt >= nt) && (rd <= nd);
   assign cov_new = (na >= ra) && (nb <= rb) && (nt >= rt) && (nd <= rd);
   assign apart   = (rb < na) || (nb < ra) || (rd < nt) || (nd < rt);

   assign e1[0] = encl(ra, rt, na, nb, nt, nd);
   assign e1[1] = encl(rb, rt, na, nb, nt, nd);
   assign e1[2] = encl(ra, rd, na, nb, nt, nd);
   assign e1[3] = encl(rb, rd, na, nb, nt, nd);
   assign e2[0] = encl(na, nt, ra, rb, rt, rd);
   assign e2[1] = encl(nb, nt, ra, rb, rt, rd);
   assign e2[2] = encl(na, nd, ra, rb, rt, rd);
   assign e2[3] = encl(nb, nd, ra, rb, rt, rd);

   assign t1 = {2'b00, e1[0]} + {2'b00, e1[1]} + {2'b00, e1[2]} + {2'b00, e1[3]};
   assign t2 = {2'b00, e2[0]} + {2'b00, e2[1]} + {2'b00, e2[2]} + {2'b00, e2[3]};
   assign both2  = (t1 == 3'd2) && (t2 == 3'd2);
   assign same_w = (res_w == new_w);
   assign same_h = (res_h == new_h);

   always_comb begin
      verdict     = V_NONE;
      piece_count = 2'd0;
      first_x     = '0;
      first_y     = '0;
      first_w     = '0;
      first_h     = '0;
      second_x    = '0;
      second_y    = '0;
      second_w    = '0;
      second_h    = '0;
      if (cov_res) begin
         verdict = V_RES_COVERED;
      end else if (cov_new) begin
         verdict = V_NEW_COVERED;
      end else if (apart) begin
         verdict = V_NONE;
      end else if (both2 && e2[0] && e2[1] && same_w) begin
         verdict = V_MERGED; piece_count = 2'd1;
         first_x = ra; first_y = rt; first_w = rws; first_h = nhs + nts - rts;
      end else if (both2 && e2[0] && e2[2] && same_h) begin
         verdict = V_MERGED; piece_count = 2'd1;
         first_x = ra; first_y = rt; first_w = nws + nas - ras; first_h = rhs;
      end else if (both2 && e2[3] && e2[1] && same_h) begin
         verdict = V_MERGED; piece_count = 2'd1;
         first_x = na; first_y = nt; first_w = rws + ras - nas; first_h = nhs;
      end else if (both2 && e2[3] && e2[2] && same_w) begin
         verdict = V_MERGED; piece_count = 2'd1;
         first_x = na; first_y = nt; first_w = nws; first_h = rhs + rts - nts;
      end else if (t2 == 3'd2) begin
         // new loses the part that lies over the resident
         verdict = V_NEW_BROKEN; piece_count = 2'd1;
         first_x = na; first_y = nt; first_w = nws; first_h = nhs;
         if (e2[0] && e2[1]) begin
            first_y = rd; first_h = nhs - (rds - nts);
         end else if (e2[0] && e2[2]) begin
            first_x = rb; first_w = nws - (rbs - nas);
         end else if (e2[3] && e2[1]) begin
            first_w = nws - (nbs - ras);
         end else if (e2[3] && e2[2]) begin
            first_h = nhs - (nds - rts);
         end
      end else if (t1 == 3'd2) begin
         verdict = V_RES_TRIMMED; piece_count = 2'd1;
         first_x = ra; first_y = rt; first_w = rws; first_h = rhs;
         if (e1[0] && e1[1]) begin
            first_y = nd; first_h = rhs - (nds - rts);
         end else if (e1[0] && e1[2]) begin
            first_x = nb; first_w = rws - (nbs - ras);
         end else if (e1[3] && e1[1]) begin
            first_w = rws - (rbs - nas);
         end else if (e1[3] && e1[2]) begin
            first_h = rhs - (rds - nts);
         end
      end else if (t2 == 3'd1) begin
         // one new corner inside the resident: l-shaped remainder in two pieces
         verdict = V_NEW_BROKEN; piece_count = 2'd2;
         first_h = nhs;
         if (e2[0]) begin
            first_x  = rb; first_y = nt; first_w = nws - rbs + nas;
            second_x = na; second_y = rd; second_w = rbs - nas;
            second_h = nhs - rds + nts;
         end else if (e2[1]) begin
            first_x  = na; first_y = nt; first_w = nws - nbs + ras;
            second_x = ra; second_y = rd; second_w = nbs - ras;
            second_h = nhs - rds + nts;
         end else if (e2[2]) begin
            first_x  = rb; first_y = nt; first_w = nws - rbs + nas;
            second_x = na; second_y = nt; second_w = rbs - nas;
            second_h = nhs - nds + rts;
         end else begin
            first_x  = na; first_y = nt; first_w = nws - nbs + ras;
            second_x = ra; second_y = nt; second_w = nbs - ras;
            second_h = nhs - nds + rts;
         end
      end else begin
         // crossing pair: cut new on both sides of the resident
         verdict = V_NEW_BROKEN; piece_count = 2'd2;
         if (new_y < res_y) begin
            first_x  = na; first_y = nt; first_w = nws; first_h = nhs - nds + rts;
            second_x = na; second_y = rd; second_w = nws; second_h = nds - rds;
         end else begin
            first_x  = na; first_y = nt; first_w = nws - nbs + ras; first_h = nhs;
            second_x = rb; second_y = nt; second_w = nbs - rbs; second_h = nhs;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/rectangle_collide_split.sv @@
// ----------------------------------------------------------------------------
// rectangle_collide_split
// Classifies a resident and a new damage rectangle and returns up to two
// result rectangles.
// ----------------------------------------------------------------------------
// A pair is taken whenever start is high and busy is low; busy is only high
// during reset, so one pair can be issued every clock. The accepting edge loads
// the input register and the next edge loads the result register through the
// classifier; rsp_valid is set at that edge and is high for exactly one cycle
// per word. The receiver cannot stall the block and must take each result
// in the cycle it is shown. Unused result rectangles read as zero; sizes are
// two's complement and may be zero or negative.
`default_nettype none

module rectangle_collide_split #(
   parameter int unsigned COORD_BITS = rcs_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [COORD_BITS-1:0]        req_res_x,
   input  logic [COORD_BITS-1:0]        req_res_y,
   input  logic [COORD_BITS-1:0]        req_res_w,
   input  logic [COORD_BITS-1:0]        req_res_h,
   input  logic [COORD_BITS-1:0]        req_new_x,
   input  logic [COORD_BITS-1:0]        req_new_y,
   input  logic [COORD_BITS-1:0]        req_new_w,
   input  logic [COORD_BITS-1:0]        req_new_h,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_verdict,
   output logic [1:0]                   rsp_piece_count,
   output logic [COORD_BITS:0]          rsp_first_x,
   output logic [COORD_BITS:0]          rsp_first_y,
   output logic signed [COORD_BITS+1:0] rsp_first_w,
   output logic signed [COORD_BITS+1:0] rsp_first_h,
   output logic [COORD_BITS:0]          rsp_second_x,
   output logic [COORD_BITS:0]          rsp_second_y,
   output logic signed [COORD_BITS+1:0] rsp_second_w,
   output logic signed [COORD_BITS+1:0] rsp_second_h
);
   import rcs_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned P = COORD_BITS + 1;
   localparam int unsigned S = COORD_BITS + 2;

   logic                  in_valid_ff, in_valid_in;
   logic [COORD_BITS-1:0] res_x_ff, res_y_ff, res_w_ff, res_h_ff;
   logic [COORD_BITS-1:0] new_x_ff, new_y_ff, new_w_ff, new_h_ff;

   verdict_type           verdict_in, verdict_ff;
   logic [1:0]            count_in, count_ff;
   logic [P-1:0]          fx_in, fy_in, sx_in, sy_in;
   logic [P-1:0]          fx_ff, fy_ff, sx_ff, sy_ff;
   logic [S-1:0]          fw_in, fh_in, sw_in, sh_in;
   logic [S-1:0]          fw_ff, fh_ff, sw_ff, sh_ff;
   logic                  out_valid_ff;

   // nothing is taken while reset holds
   assign busy        = reset;
   assign in_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         res_x_ff <= req_res_x;
         res_y_ff <= req_res_y;
         res_w_ff <= req_res_w;
         res_h_ff <= req_res_h;
         new_x_ff <= req_new_x;
         new_y_ff <= req_new_y;
         new_w_ff <= req_new_w;
         new_h_ff <= req_new_h;
      end
   end

   rcs_classify #(
      .COORD_BITS (COORD_BITS)
   ) u_classify (
      .res_x       (res_x_ff),
      .res_y       (res_y_ff),
      .res_w       (res_w_ff),
      .res_h       (res_h_ff),
      .new_x       (new_x_ff),
      .new_y       (new_y_ff),
      .new_w       (new_w_ff),
      .new_h       (new_h_ff),
      .verdict     (verdict_in),
      .piece_count (count_in),
      .first_x     (fx_in),
      .first_y     (fy_in),
      .first_w     (fw_in),
      .first_h     (fh_in),
      .second_x    (sx_in),
      .second_y    (sy_in),
      .second_w    (sw_in),
      .second_h    (sh_in)
   );

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         verdict_ff <= verdict_in;
         count_ff   <= count_in;
         fx_ff      <= fx_in;
         fy_ff      <= fy_in;
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         sw_ff      <= sw_in;
         sh_ff      <= sh_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_piece_count = count_ff;
   assign rsp_first_x     = fx_ff;
   assign rsp_first_y     = fy_ff;
   assign rsp_first_w     = fw_ff;
   assign rsp_first_h     = fh_ff;
   assign rsp_second_x    = sx_ff;
   assign rsp_second_y    = sy_ff;
   assign rsp_second_w    = sw_ff;
   assign rsp_second_h    = sh_ff;

   // every taken pair yields its word through the input and result registers
   `ASSERT_IMPLIES(a_latency, clock, reset, start && !busy, ##2 rsp_valid)
   // no word without a taken pair behind it
   `ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_valid, $past(start && !busy, 2))
   // merged or trimmed pairs carry exactly one piece
   `ASSERT_IMPLIES(a_one_piece, clock, reset,
      rsp_valid && (verdict_ff == V_MERGED || verdict_ff == V_RES_TRIMMED),
      count_ff == 2'd1)
   // second piece reads as zero unless two pieces are given
   `ASSERT_IMPLIES(a_second_zero, clock, reset, rsp_valid && count_ff != 2'd2,
      sx_ff == '0 && sy_ff == '0 && sw_ff == '0 && sh_ff == '0)

endmodule

`default_nettype wire

@@ sim/rectangle_collide_split_tb.sv @@
// ----------------------------------------------------------------------------
// rectangle_collide_split_tb
// Self-checking bench for the rectangle collision splitter. Rectangle pairs
// are fed from a backlog with random gaps. Each pair is classified by a local
// predictor when it is taken, and every returned word is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------

module rectangle_collide_split_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rcs_pkg::*;

   localparam int CB           = COORD_BITS_DEF;
   localparam int MAXC         = (1 << CB) - 1;
   localparam int LATENCY      = 2;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_PAIRS = 830;

   typedef struct packed {
      logic [CB-1:0] res_x, res_y, res_w, res_h;
      logic [CB-1:0] new_x, new_y, new_w, new_h;
   } rect_pair_type;

   typedef struct packed {
      logic          drain;
      rect_pair_type pair;
   } pending_type;

   typedef struct packed {
      logic [CB:0]          x, y;
      logic signed [CB+1:0] w, h;
   } piece_type;

   typedef struct packed {
      verdict_type verdict;
      logic [1:0]  count;
      piece_type   first, second;
   } split_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CB-1:0] req_res_x = '0, req_res_y = '0, req_res_w = '0, req_res_h = '0;
   logic [CB-1:0] req_new_x = '0, req_new_y = '0, req_new_w = '0, req_new_h = '0;
   logic                 rsp_valid;
   logic [2:0]           rsp_verdict;
   logic [1:0]           rsp_piece_count;
   logic [CB:0]          rsp_first_x, rsp_first_y, rsp_second_x, rsp_second_y;
   logic signed [CB+1:0] rsp_first_w, rsp_first_h, rsp_second_w, rsp_second_h;

   pending_type      pair_backlog[$];
   split_result_type split_due_q[$];
   rect_pair_type    shown_pair;
   int               pairs_total  = 0;
   int               pairs_taken  = 0;
   int               splits_seen  = 0;
   int               mismatch_cnt = 0;
   int               gap_left     = 0;
   int               burst_left   = 0;
   int               idle_cycles  = 0;

   rectangle_collide_split #(.COORD_BITS(CB)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_res_x       (req_res_x),
      .req_res_y       (req_res_y),
      .req_res_w       (req_res_w),
      .req_res_h       (req_res_h),
      .req_new_x       (req_new_x),
      .req_new_y       (req_new_y),
      .req_new_w       (req_new_w),
      .req_new_h       (req_new_h),
      .rsp_valid       (rsp_valid),
      .rsp_verdict     (rsp_verdict),
      .rsp_piece_count (rsp_piece_count),
      .rsp_first_x     (rsp_first_x),
      .rsp_first_y     (rsp_first_y),
      .rsp_first_w     (rsp_first_w),
      .rsp_first_h     (rsp_first_h),
      .rsp_second_x    (rsp_second_x),
      .rsp_second_y    (rsp_second_y),
      .rsp_second_w    (rsp_second_w),
      .rsp_second_h    (rsp_second_h)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit corner_in(int px, int py, int lx, int hx, int ly, int hy);
      return px >= lx && px <= hx && py >= ly && py <= hy;
   endfunction

   function automatic split_result_type classify_pair(rect_pair_type p);
      int ra, rb, rt, rd, rw, rh;
      int na, nb, nt, nd, nw, nh;
      int f[4], s[4];
      int cnt, on_new, on_res;
      bit [3:0] rc, nc;
      bit merged;
      verdict_type v;
      split_result_type r;
      ra = int'(p.res_x);  rt = int'(p.res_y);
      rw = int'(p.res_w);  rh = int'(p.res_h);
      na = int'(p.new_x);  nt = int'(p.new_y);
      nw = int'(p.new_w);  nh = int'(p.new_h);
      rb = ra + rw;  rd = rt + rh;
      nb = na + nw;  nd = nt + nh;
      f = '{0, 0, 0, 0};
      s = '{0, 0, 0, 0};
      cnt = 0;
      merged = 1'b0;
      if (ra >= na && rb <= nb && rt >= nt && rd <= nd) begin
         v = V_RES_COVERED;
      end else if (na >= ra && nb <= rb && nt >= rt && nd <= rd) begin
         v = V_NEW_COVERED;
      end else if (rb < na || nb < ra || rd < nt || nd < rt) begin
         v = V_NONE;
      end else begin
         // corner order: top-left, top-right, bottom-left, bottom-right
         rc[0] = corner_in(ra, rt, na, nb, nt, nd);
         rc[1] = corner_in(rb, rt, na, nb, nt, nd);
         rc[2] = corner_in(ra, rd, na, nb, nt, nd);
         rc[3] = corner_in(rb, rd, na, nb, nt, nd);
         nc[0] = corner_in(na, nt, ra, rb, rt, rd);
         nc[1] = corner_in(nb, nt, ra, rb, rt, rd);
         nc[2] = corner_in(na, nd, ra, rb, rt, rd);
         nc[3] = corner_in(nb, nd, ra, rb, rt, rd);
         on_new = $countones(rc);
         on_res = $countones(nc);
         if (on_new == 2 && on_res == 2) begin
            merged = 1'b1;
            if (nc[0] && nc[1] && rw == nw)      f = '{ra, rt, rw, nh + nt - rt};
            else if (nc[0] && nc[2] && rh == nh) f = '{ra, rt, nw + na - ra, rh};
            else if (nc[3] && nc[1] && rh == nh) f = '{na, nt, rw + ra - na, nh};
            else if (nc[3] && nc[2] && rw == nw) f = '{na, nt, nw, rh + rt - nt};
            else merged = 1'b0;
         end
         if (merged) begin
            v = V_MERGED;
            cnt = 1;
         end else if (on_res == 2) begin
            v = V_NEW_BROKEN;
            cnt = 1;
            f = '{na, nt, nw, nh};
            if (nc[0] && nc[1]) begin
               f[1] = rd;
               f[3] = f[3] - (rd - nt);
            end else if (nc[0] && nc[2]) begin
               f[0] = rb;
               f[2] = f[2] - (rb - na);
            end else if (nc[3] && nc[1]) begin
               f[2] = f[2] - (nb - ra);
            end else if (nc[3] && nc[2]) begin
               f[3] = f[3] - (nd - rt);
            end
         end else if (on_new == 2) begin
            v = V_RES_TRIMMED;
            cnt = 1;
            f = '{ra, rt, rw, rh};
            if (rc[0] && rc[1]) begin
               f[1] = nd;
               f[3] = f[3] - (nd - rt);
            end else if (rc[0] && rc[2]) begin
               f[0] = nb;
               f[2] = f[2] - (nb - ra);
            end else if (rc[3] && rc[1]) begin
               f[2] = f[2] - (rb - na);
            end else if (rc[3] && rc[2]) begin
               f[3] = f[3] - (rd - nt);
            end
         end else if (on_res == 1) begin
            v = V_NEW_BROKEN;
            cnt = 2;
            if (nc[0]) begin
               f = '{rb, nt, nw - rb + na, nh};
               s = '{na, rd, rb - na, nh - rd + nt};
            end else if (nc[1]) begin
               f = '{na, nt, nw - nb + ra, nh};
               s = '{ra, rd, nb - ra, nh - rd + nt};
            end else if (nc[2]) begin
               f = '{rb, nt, nw - rb + na, nh};
               s = '{na, nt, rb - na, nh - nd + rt};
            end else begin
               f = '{na, nt, nw - nb + ra, nh};
               s = '{ra, nt, nb - ra, nh - nd + rt};
            end
         end else begin
            // new rectangle crosses the resident one
            v = V_NEW_BROKEN;
            cnt = 2;
            if (nt < rt) begin
               f = '{na, nt, nw, nh - nd + rt};
               s = '{na, rd, nw, nd - rd};
            end else begin
               f = '{na, nt, nw - nb + ra, nh};
               s = '{rb, nt, nb - rb, nh};
            end
         end
      end
      r.verdict   = v;
      r.count     = cnt[1:0];
      r.first.x   = f[0][CB:0];
      r.first.y   = f[1][CB:0];
      r.first.w   = f[2][CB+1:0];
      r.first.h   = f[3][CB+1:0];
      r.second.x  = s[0][CB:0];
      r.second.y  = s[1][CB:0];
      r.second.w  = s[2][CB+1:0];
      r.second.h  = s[3][CB+1:0];
      return r;
   endfunction

   // an edge position near or at one of the two bounds, between them or beyond
   function automatic int pick_bound(int lo, int hi);
      int v;
      case ($urandom_range(0, 5))
         0: v = lo;
         1: v = hi;
         2: v = lo + int'($urandom_range(0, 6)) - 3;
         3: v = hi + int'($urandom_range(0, 6)) - 3;
         4: v = int'($urandom_range(lo, hi));
         default: v = $urandom_range(0, 1) ? lo - int'($urandom_range(1, 300))
                                           : hi + int'($urandom_range(1, 300));
      endcase
      return (v < 0) ? 0 : (v > MAXC) ? MAXC : v;
   endfunction

   function automatic void span_around(input int lo, input int hi,
                                       output int pos, output int len);
      int e0, e1, t;
      e0 = pick_bound(lo, hi);
      e1 = pick_bound(lo, hi);
      if (e1 < e0) begin
         t = e0;
         e0 = e1;
         e1 = t;
      end
      pos = e0;
      len = e1 - e0;
   endfunction

   function automatic rect_pair_type random_pair();
      int mode, rx, ry, rw, rh, nx, ny, nw, nh;
      rect_pair_type p;
      mode = $urandom_range(0, 19);
      if (mode < 2) begin
         rx = $urandom_range(0, MAXC);  ry = $urandom_range(0, MAXC);
         rw = $urandom_range(0, MAXC);  rh = $urandom_range(0, MAXC);
         nx = $urandom_range(0, MAXC);  ny = $urandom_range(0, MAXC);
         nw = $urandom_range(0, MAXC);  nh = $urandom_range(0, MAXC);
      end else if (mode < 4) begin
         rx = $urandom_range(0, 31);  ry = $urandom_range(0, 31);
         rw = $urandom_range(0, 31);  rh = $urandom_range(0, 31);
         nx = $urandom_range(0, 31);  ny = $urandom_range(0, 31);
         nw = $urandom_range(0, 31);  nh = $urandom_range(0, 31);
      end else begin
         rw = $urandom_range(0, 250);
         rh = $urandom_range(0, 250);
         rx = $urandom_range(0, MAXC - rw);
         ry = $urandom_range(0, MAXC - rh);
         span_around(rx, rx + rw, nx, nw);
         span_around(ry, ry + rh, ny, nh);
         // one axis lined up exactly, so merges come up often
         if (mode < 8) begin
            if (mode[0]) begin
               nx = rx;
               nw = rw;
            end else begin
               ny = ry;
               nh = rh;
            end
         end
      end
      p.res_x = rx[CB-1:0];  p.res_y = ry[CB-1:0];
      p.res_w = rw[CB-1:0];  p.res_h = rh[CB-1:0];
      p.new_x = nx[CB-1:0];  p.new_y = ny[CB-1:0];
      p.new_w = nw[CB-1:0];  p.new_h = nh[CB-1:0];
      return p;
   endfunction

   task automatic add_pair(input int rx, input int ry, input int rw, input int rh,
                           input int nx, input int ny, input int nw, input int nh);
      pending_type item;
      item.drain = 1'b0;
      item.pair.res_x = rx[CB-1:0];  item.pair.res_y = ry[CB-1:0];
      item.pair.res_w = rw[CB-1:0];  item.pair.res_h = rh[CB-1:0];
      item.pair.new_x = nx[CB-1:0];  item.pair.new_y = ny[CB-1:0];
      item.pair.new_w = nw[CB-1:0];  item.pair.new_h = nh[CB-1:0];
      pair_backlog.push_back(item);
   endtask

   function automatic logic signed [31:0] pos32(logic [CB:0] v);
      return {{(31 - CB){1'b0}}, v};
   endfunction

   function automatic logic signed [31:0] size32(logic [CB+1:0] v);
      return {{(30 - CB){v[CB+1]}}, v};
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_cnt++;
      end
   endtask

   // driver: one pair on the req_ ports while start is high
   always @(posedge clock) begin : drive
      bit taken;
      bit waiting;
      int gap;
      int roll;
      pending_type nxt;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         taken = start && !busy;
         gap = gap_left;
         if (taken) begin
            split_due_q.push_back(classify_pair(shown_pair));
            pairs_taken <= pairs_taken + 1;
            if (burst_left > 0) begin
               burst_left--;
               gap = 0;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 4) burst_left = $urandom_range(20, 60);
               if (roll < 65) gap = 0;
               else if (roll < 93) gap = $urandom_range(1, 3);
               else gap = $urandom_range(8, 40);
            end
         end
         waiting = taken || pairs_taken != splits_seen;
         if (start && !taken) begin
            start <= 1'b1;
         end else if (gap > 0) begin
            start <= 1'b0;
            gap_left <= gap - 1;
         end else if (pair_backlog.size() > 0 && !(pair_backlog[0].drain && waiting)) begin
            nxt = pair_backlog.pop_front();
            shown_pair = nxt.pair;
            req_res_x <= nxt.pair.res_x;
            req_res_y <= nxt.pair.res_y;
            req_res_w <= nxt.pair.res_w;
            req_res_h <= nxt.pair.res_h;
            req_new_x <= nxt.pair.new_x;
            req_new_y <= nxt.pair.new_y;
            req_new_w <= nxt.pair.new_w;
            req_new_h <= nxt.pair.new_h;
            start <= 1'b1;
            gap_left <= 0;
         end else begin
            start <= 1'b0;
            gap_left <= 0;
         end
      end
   end

   // monitor: every rsp word is compared with the oldest prediction
   always @(posedge clock) begin : observe
      split_result_type due;
      if (!reset && rsp_valid) begin
         splits_seen <= splits_seen + 1;
         if (split_due_q.size() == 0) begin
            $error("result word with no pair outstanding");
            mismatch_cnt++;
         end else begin
            due = split_due_q.pop_front();
            check_field("verdict", {29'b0, due.verdict}, {29'b0, rsp_verdict});
            check_field("piece_count", {30'b0, due.count}, {30'b0, rsp_piece_count});
            check_field("first_x", pos32(due.first.x), pos32(rsp_first_x));
            check_field("first_y", pos32(due.first.y), pos32(rsp_first_y));
            check_field("first_w", size32(due.first.w), size32(rsp_first_w));
            check_field("first_h", size32(due.first.h), size32(rsp_first_h));
            check_field("second_x", pos32(due.second.x), pos32(rsp_second_x));
            check_field("second_y", pos32(due.second.y), pos32(rsp_second_y));
            check_field("second_w", size32(due.second.w), size32(rsp_second_w));
            check_field("second_h", size32(due.second.h), size32(rsp_second_h));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL rectangle_collide_split");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      pending_type item;
      int i;
      add_pair(0, 0, 0, 0, 0, 0, 0, 0);
      add_pair(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
      add_pair(0, 0, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
      add_pair(0, 0, 0, 0, MAXC, 0, 0, MAXC);
      add_pair(100, 100, 50, 50, 100, 100, 50, 50);
      add_pair(100, 100, 50, 50, 90, 90, 80, 80);
      add_pair(100, 100, 50, 50, 110, 110, 10, 10);
      add_pair(100, 100, 50, 50, 200, 100, 10, 10);
      add_pair(100, 100, 50, 50, 100, 20, 50, 70);
      // shared edge only, counts as touching
      add_pair(100, 100, 50, 50, 150, 100, 20, 50);
      add_pair(100, 100, 50, 50, 100, 120, 50, 60);
      add_pair(100, 100, 50, 50, 100, 60, 50, 60);
      add_pair(100, 100, 50, 50, 60, 100, 60, 50);
      add_pair(100, 100, 50, 50, 120, 130, 10, 40);
      add_pair(100, 100, 50, 50, 120, 80, 10, 40);
      add_pair(100, 100, 50, 50, 130, 120, 40, 10);
      add_pair(100, 100, 50, 50, 90, 130, 80, 40);
      add_pair(100, 100, 50, 50, 130, 130, 40, 40);
      add_pair(100, 100, 50, 50, 80, 130, 40, 40);
      add_pair(100, 100, 50, 50, 130, 80, 40, 40);
      add_pair(100, 100, 50, 50, 80, 80, 40, 40);
      add_pair(100, 100, 50, 50, 120, 80, 10, 100);
      add_pair(100, 100, 50, 50, 80, 120, 100, 10);
      add_pair(100, 100, 0, 50, 100, 80, 0, 100);
      add_pair(8000, 8000, MAXC, MAXC, 8100, 8100, MAXC, MAXC);
      for (i = 0; i < RANDOM_PAIRS; i++) begin
         // now and then hold off until the block has drained
         item.drain = (i % 150 == 0);
         item.pair = random_pair();
         pair_backlog.push_back(item);
      end
      pairs_total = pair_backlog.size();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pairs_taken != pairs_total || splits_seen != pairs_total) @(posedge clock);
      repeat (LATENCY + 6) @(posedge clock);
      if (split_due_q.size() != 0) begin
         $error("%0d result words never arrived", split_due_q.size());
         mismatch_cnt++;
      end
      if (mismatch_cnt == 0) begin
         $display("PASS rectangle_collide_split");
      end else begin
         $display("FAIL rectangle_collide_split");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/rcs_pkg.sv
hdl/rcs_classify.sv
hdl/rectangle_collide_split.sv
sim/rectangle_collide_split_tb.sv
